// ===== rtl/aeig_pkg.sv =====
`timescale 1ns / 1ps
package aeig_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	localparam int IW_BITS = 11;
	localparam int GS_BITS = 9;

	localparam logic [IW_BITS-1:0] IW_RESET = 11'd1024;
	localparam logic [GS_BITS-1:0] GS_RESET = 9'd256;
	localparam logic [GS_BITS-1:0] GS_FULL  = 9'd256;

	// register index = paddr[2]
	localparam logic REG_IMAGE_WIDTH   = 1'b0;
	localparam logic REG_GLOW_STRENGTH = 1'b1;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// rows held in the line stores
	localparam logic [1:0] ROWS_NONE = 2'd0;
	localparam logic [1:0] ROWS_ONE  = 2'd1;
	localparam logic [1:0] ROWS_TWO  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_PROD,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/alpha_erosion_inner_glow.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    action, red_in, green_in, blue_in, alpha_in
// output    out        out_valid/out_ready  red_out, green_out, blue_out, alpha_out,
//                                           row_end, frame_end
// config    in         APB psel/penable     paddr, pwdata, prdata (image_width @0, glow @4)
//
// Flow: an item of the first row is stored in the cycle it is accepted. Every later item
// with nonzero alpha passes memory read of the center pixel, read of its right neighbor
// through the same port, erosion and products, numerator, the shared-control restoring
// divider (one quotient bit per cycle), then the output load. A later item with zero
// alpha skips the numerator and the divider. Input is taken only in ST_IDLE. Reset
// clears the FSM, column, row count, left alpha, divider count and the output valid; the
// line stores hold garbage until written. A stalled output holds the finished item in
// ST_DONE while the output register is full; then it loads and the FSM returns to ST_IDLE.
module alpha_erosion_inner_glow
	import aeig_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic [7:0]  alpha_in,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [7:0]  alpha_out,
	output logic        row_end,
	output logic        frame_end,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = (CW + 1 > IW_BITS + 1) ? CW + 1 : IW_BITS + 1;

	// ---------------- configuration ----------------
	logic [IW_BITS-1:0] iw_q;
	logic [GS_BITS-1:0] gs_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q <= IW_RESET;
			gs_q <= GS_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_IMAGE_WIDTH:   iw_q <= pwdata[IW_BITS-1:0];
				REG_GLOW_STRENGTH: gs_q <= pwdata[GS_BITS-1:0];
				default:           iw_q <= iw_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_IMAGE_WIDTH:   prdata = {{(32-IW_BITS){1'b0}}, iw_q};
			REG_GLOW_STRENGTH: prdata = {{(32-GS_BITS){1'b0}}, gs_q};
			default:           prdata = '0;
		endcase
	end

	// ---------------- control state ----------------
	state_t          state_q, state_nx;
	logic [CW-1:0]   col_q;
	logic [1:0]      rows_q;
	logic [7:0]      left_q;
	logic [2:0]      cnt_q;

	// active width and saturated column
	logic [WW-1:0] iw_ext, w_ext, col_ext, col_sat;
	logic [CW-1:0] col_cur;
	logic          last_cur, right_cur;
	logic          in_acc;

	always_comb begin
		iw_ext  = {{(WW-IW_BITS){1'b0}}, iw_q};
		if (iw_ext == '0)
			w_ext = WW'(1);
		else if (iw_ext > WW'(MAX_WIDTH))
			w_ext = WW'(MAX_WIDTH);
		else
			w_ext = iw_ext;
		col_ext   = {{(WW-CW){1'b0}}, col_q};
		col_sat   = (col_ext >= w_ext) ? (w_ext - WW'(1)) : col_ext;
		col_cur   = col_sat[CW-1:0];
		last_cur  = (col_sat == w_ext - WW'(1));
		right_cur = (col_sat + WW'(1) < w_ext);
	end

	assign in_acc = in_valid & in_ready;

	// ---------------- item registers ----------------
	logic            drain_s1, last_s1, right_s1;
	logic [CW-1:0]   col_s1;
	logic [31:0]     newpix_s1;
	logic [31:0]     centre_s2;
	logic [7:0]      up_s2;

	// ---------------- line stores ----------------
	logic [31:0]   pix_mem [MAX_WIDTH];
	logic [7:0]    alpha_mem [MAX_WIDTH];
	logic [31:0]   pix_rdata_q;
	logic [7:0]    alpha_rdata_q;
	logic          pix_we, alpha_we;
	logic [CW-1:0] pix_waddr, pix_raddr;
	logic [31:0]   pix_wdata;

	always_ff @(posedge clk) begin
		if (pix_we)
			pix_mem[pix_waddr] <= pix_wdata;
		pix_rdata_q <= pix_mem[pix_raddr];
	end

	always_ff @(posedge clk) begin
		if (alpha_we)
			alpha_mem[col_s1] <= centre_s2[31:24];
		alpha_rdata_q <= alpha_mem[col_cur];
	end

	// ---------------- FSM ----------------
	logic out_free;
	assign out_free = ~out_valid | out_ready;

	logic [7:0] a_c;
	assign a_c = centre_s2[31:24];

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (in_acc && rows_q != ROWS_NONE) state_nx = ST_READ;
			ST_READ: state_nx = ST_MUL;
			ST_MUL:  state_nx = (a_c == 8'd0) ? ST_DONE : ST_PROD;
			ST_PROD: state_nx = ST_DIV;
			ST_DIV:  if (cnt_q == 3'd0) state_nx = ST_DONE;
			ST_DONE: if (out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		pix_we    = 1'b0;
		alpha_we  = 1'b0;
		pix_waddr = col_s1;
		pix_wdata = newpix_s1;
		pix_raddr = col_cur;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				pix_waddr = col_cur;
				pix_wdata = {alpha_in, blue_in, green_in, red_in};
				pix_we    = in_acc && rows_q == ROWS_NONE && action == ACT_PIXEL;
			end
			ST_READ: begin
				pix_raddr = col_s1 + CW'(1);   // right neighbor; unused past the row end
			end
			ST_MUL: begin
				pix_we   = ~drain_s1;
				alpha_we = 1'b1;
			end
			default: ;
		endcase
	end

	// ---------------- datapath ----------------
	logic [7:0]  right_a, down_a, left_a, ero, rim;
	logic [8:0]  g_sat;
	logic [16:0] gr_s3;
	logic [15:0] ac_s3 [3];
	logic [15:0] rem_q [3];
	logic [7:0]  res_q [3];
	logic signed [27:0] num [3];
	logic [15:0] trial;

	always_comb begin
		right_a = right_s1 ? pix_rdata_q[31:24] : 8'd0;
		down_a  = (drain_s1 == ACT_DRAIN) ? 8'd0 : newpix_s1[31:24];
		left_a  = (col_s1 != '0) ? left_q : 8'd0;
		ero = a_c;
		if (up_s2 < ero)   ero = up_s2;
		if (down_a < ero)  ero = down_a;
		if (left_a < ero)  ero = left_a;
		if (right_a < ero) ero = right_a;
		rim   = a_c - ero;
		g_sat = (gs_q > GS_FULL) ? GS_FULL : gs_q;
	end

	// num = 256*a*c + g*rim*(a-c) + 128*a, never negative and below 2^24
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num[k] = $signed({4'b0, ac_s3[k], 8'b0})
			       + $signed({11'b0, gr_s3})
			         * ($signed({20'b0, a_c}) - $signed({20'b0, centre_s2[8*k +: 8]}))
			       + $signed({13'b0, a_c, 7'b0});
		end
		trial = {8'b0, a_c} << cnt_q;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			drain_s1  <= action;
			last_s1   <= last_cur;
			right_s1  <= right_cur;
			col_s1    <= col_cur;
			newpix_s1 <= {alpha_in, blue_in, green_in, red_in};
		end
		case (state_q)
			ST_READ: begin
				centre_s2 <= pix_rdata_q;
				up_s2     <= (rows_q == ROWS_TWO) ? alpha_rdata_q : 8'd0;
			end
			ST_MUL: begin
				gr_s3 <= g_sat * rim;
				for (int k = 0; k < 3; k++) begin
					ac_s3[k] <= a_c * centre_s2[8*k +: 8];
					res_q[k] <= centre_s2[8*k +: 8];   // zero alpha passes unchanged
				end
			end
			ST_PROD: begin
				for (int k = 0; k < 3; k++) begin
					rem_q[k] <= num[k][23:8];
					res_q[k] <= '0;
				end
			end
			ST_DIV: begin
				for (int k = 0; k < 3; k++) begin
					if (rem_q[k] >= trial) begin
						rem_q[k]        <= rem_q[k] - trial;
						res_q[k][cnt_q] <= 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			rows_q  <= ROWS_NONE;
			left_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			// first row: store and advance in the accept cycle; drains ignored
			if (state_q == ST_IDLE && in_acc && rows_q == ROWS_NONE
			    && action == ACT_PIXEL) begin
				if (last_cur) begin
					col_q  <= '0;
					rows_q <= ROWS_ONE;
				end else begin
					col_q <= col_cur + CW'(1);
				end
			end
			if (state_q == ST_MUL) begin
				left_q <= a_c;
				if (last_s1) begin
					col_q  <= '0;
					rows_q <= (drain_s1 == ACT_DRAIN) ? ROWS_NONE : ROWS_TWO;
				end else begin
					col_q <= col_s1 + CW'(1);
				end
			end
			if (state_q == ST_PROD)
				cnt_q <= 3'd7;
			else if (state_q == ST_DIV)
				cnt_q <= cnt_q - 3'd1;
		end
	end

	// ---------------- output register ----------------
	logic       out_valid_q;
	logic [7:0] red_q, green_q, blue_q, alpha_q;
	logic       row_end_q, frame_end_q;
	logic       out_load;

	assign out_load = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			red_q       <= res_q[0];
			green_q     <= res_q[1];
			blue_q      <= res_q[2];
			alpha_q     <= a_c;
			row_end_q   <= last_s1;
			frame_end_q <= last_s1 & (drain_s1 == ACT_DRAIN);
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign alpha_out = alpha_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

endmodule
